// File: sv/arena_first_fit_allocator_top_macros.svh
// assertion macros for the arena allocator
`ifndef ARENA_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH
`define ARENA_FIRST_FIT_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// checked property, disabled while reset is high
`define AFFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also active during reset
`define AFFA_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AFFA_ASSERT(lbl, clk, rst, prop, msg)
`define AFFA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: sv/affa_pkg.sv
package affa_pkg;

   localparam int MAX_SPANS  = 32;
   localparam int ADDR_BITS  = 32;
   localparam int IDX_W      = $clog2(MAX_SPANS + 2);
   localparam int MEM_DEPTH  = 2 ** (IDX_W + 1);
   localparam int DIV_BITS   = 4;
   localparam int DIV_STEPS  = 32 / DIV_BITS;
   localparam int DIVC_W     = $clog2(DIV_STEPS);

   localparam logic [31:0] CAP_RESET = 32'h0400_0000;
   localparam logic [32:0] ADDR_MASK = 33'((64'd1 << ADDR_BITS) - 64'd1);

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_RESET = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
   localparam logic [1:0] ST_CAP_EXC   = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef logic [IDX_W-1:0] idx_type;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] limit;
   } span_type;

endpackage

// File: sv/arena_first_fit_allocator_top.sv
// channel | ports                                            | direction
// req     | req_valid req_ready req_opcode req_size          | in
//         | req_alignment req_free_offset                    |
// rsp     | rsp_valid rsp_ready rsp_status rsp_slice_offset  | out
//         | rsp_from_free_list                               |
// csr     | csr_wr_en csr_wr_data (arena capacity)           | in
//
// allocate: each span scanned is read, run through the 8-step remainder unit and checked;
//   on a fit the later entries are shifted down, and with no fit the cursor path runs
// free: every stored span is ranked by a scan of the whole list in the ranking pass
//   over the single read port of the span memory
// reset and zero-size requests go straight to the result; one request in work at a time
// synchronous reset empties the list and cursor and loads the 64 MiB capacity
// a new request is taken while a result waits on rsp; the block stalls only
//   when a second result is ready before the first transfer
module arena_first_fit_allocator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_size,
   input  logic [15:0] req_alignment,
   input  logic [31:0] req_free_offset,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_slice_offset,
   output logic        rsp_from_free_list,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import affa_pkg::*;
`include "arena_first_fit_allocator_top_macros.svh"

   typedef enum logic [4:0] {
      S_IDLE, S_AL_RD, S_AL_DATA, S_DIV, S_AL_CHK, S_SH_RD, S_SH_WR, S_AP_GAP,
      S_AP_REM, S_CUR_CHK, S_FR_WR, S_RK_RDI, S_RK_GETI, S_RK_SCAN, S_MG_START,
      S_MG_RUN, S_MG_FIN, S_RESP
   } state_type;

   // two banks of spans: the live list and a scratch list for the sort-merge
   span_type mem_ff [MEM_DEPTH];
   span_type rd_data_ff;
   logic [IDX_W:0] rd_addr_in, wr_addr_in;
   logic           wr_en_in;
   span_type       wr_data_in;

   state_type   state_ff;
   logic        bank_ff;
   idx_type     span_count_ff;
   logic [31:0] cursor_ff;
   logic [31:0] cap_ff;

   // request and work registers
   logic [31:0] size_ff;
   logic [15:0] align_ff;
   logic [31:0] s_ff, e_ff, o_ff, e2_ff;
   idx_type     i_ff, j_ff, w_ff, rank_ff, kept_ff, new_count_ff;
   logic        gap_ff, rem_flag_ff, have_ff, div_cur_ff;
   span_type    cur_ff;

   // remainder unit
   logic [31:0]       dv_ff;
   logic [15:0]       rem_ff;
   logic [DIVC_W-1:0] dc_ff;
   logic [31:0]       dv_in;
   logic [15:0]       rem_in;

   // pending result and output register
   logic [1:0]  res_status_ff;
   logic [31:0] res_slice_ff;
   logic        res_from_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_slice_ff;
   logic        rsp_from_ff;

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_slice_offset   = rsp_slice_ff;
   assign rsp_from_free_list = rsp_from_ff;

   // restoring remainder, DIV_BITS quotient bits per cycle
   always_comb begin
      logic [16:0] r;
      logic [31:0] v;
      r = {1'b0, rem_ff};
      v = dv_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         r = {r[15:0], v[31]};
         v = {v[30:0], 1'b0};
         if (r >= {1'b0, align_ff}) r = r - {1'b0, align_ff};
      end
      dv_in  = v;
      rem_in = r[15:0];
   end

   // round up to the alignment, then the end of the slice
   logic [31:0] round_base;
   logic [32:0] round_o;
   logic [33:0] slice_end;
   assign round_base = div_cur_ff ? cursor_ff : s_ff;
   assign round_o    = (align_ff == '0 || rem_ff == '0) ? {1'b0, round_base}
                     : {1'b0, round_base} + {17'd0, align_ff - rem_ff};
   assign slice_end  = {1'b0, round_o} + {2'b0, size_ff};

   logic    fit_c, gap_c, rem_c;
   idx_type m_c;
   assign fit_c = slice_end <= {2'b0, e_ff};
   assign gap_c = round_o > {1'b0, s_ff};
   assign rem_c = slice_end < {2'b0, e_ff};
   assign m_c   = span_count_ff - 1'b1 + idx_type'(gap_c) + idx_type'(rem_c);

   // scan of the ranking and merge passes: data of entry j-1 is on the read port
   idx_type scan_idx, rank_next;
   logic    scan_last, less_c, nz_c, mrg_c;
   assign scan_idx  = j_ff - 1'b1;
   assign scan_last = (scan_idx == span_count_ff);
   assign less_c    = (rd_data_ff.base < s_ff)
                   || (rd_data_ff.base == s_ff && scan_idx < i_ff);
   assign rank_next = rank_ff + idx_type'(less_c);
   assign nz_c      = rd_data_ff.limit != rd_data_ff.base;
   assign mrg_c     = have_ff && (cur_ff.limit >= rd_data_ff.base);

   // freed span, clipped to the address space
   logic [32:0] f_off_c, f_end_raw, f_end_c;
   assign f_off_c   = ({1'b0, req_free_offset} > ADDR_MASK) ? ADDR_MASK
                    : {1'b0, req_free_offset};
   assign f_end_raw = f_off_c + {1'b0, req_size};
   assign f_end_c   = (f_end_raw > ADDR_MASK) ? ADDR_MASK : f_end_raw;

   idx_type total_c;
   assign total_c = kept_ff + idx_type'(have_ff);

   // memory port control
   always_comb begin
      rd_addr_in = {bank_ff, i_ff};
      wr_en_in   = 1'b0;
      wr_addr_in = {bank_ff, w_ff};
      wr_data_in = cur_ff;
      case (state_ff)
         S_SH_RD:    rd_addr_in = {bank_ff, j_ff + 1'b1};
         S_SH_WR: begin
            wr_en_in   = 1'b1;
            wr_addr_in = {bank_ff, j_ff};
            wr_data_in = rd_data_ff;
         end
         S_AP_GAP: begin
            wr_en_in   = gap_ff;
            wr_data_in = '{base: s_ff, limit: o_ff};
         end
         S_AP_REM: begin
            wr_en_in   = rem_flag_ff;
            wr_data_in = '{base: e2_ff, limit: e_ff};
         end
         S_FR_WR: begin
            wr_en_in   = 1'b1;
            wr_addr_in = {bank_ff, span_count_ff};
            wr_data_in = '{base: s_ff, limit: e_ff};
         end
         S_RK_GETI:  rd_addr_in = {bank_ff, idx_type'(0)};
         S_RK_SCAN: begin
            rd_addr_in = {bank_ff, j_ff};
            wr_en_in   = scan_last;
            wr_addr_in = {~bank_ff, rank_next};
            wr_data_in = '{base: s_ff, limit: e_ff};
         end
         S_MG_START: rd_addr_in = {~bank_ff, idx_type'(0)};
         S_MG_RUN: begin
            rd_addr_in = {~bank_ff, j_ff};
            wr_en_in   = nz_c && !mrg_c && have_ff;
            wr_addr_in = {~bank_ff, kept_ff};
         end
         S_MG_FIN: begin
            wr_en_in   = have_ff;
            wr_addr_in = {~bank_ff, kept_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en_in) mem_ff[wr_addr_in] <= wr_data_in;
      rd_data_ff <= mem_ff[rd_addr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bank_ff       <= 1'b0;
         span_count_ff <= '0;
         cursor_ff     <= '0;
         cap_ff        <= CAP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         // the result state reloads the output register itself
         if (rsp_ready && state_ff != S_RESP) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  size_ff       <= req_size;
                  align_ff      <= req_alignment;
                  i_ff          <= '0;
                  res_status_ff <= ST_OK;
                  res_slice_ff  <= '0;
                  res_from_ff   <= 1'b0;
                  case (req_opcode)
                     OP_ALLOC: begin
                        if (req_size == '0) begin
                           res_status_ff <= ST_ZERO_SIZE;
                           state_ff      <= S_RESP;
                        end else begin
                           state_ff <= S_AL_RD;
                        end
                     end
                     OP_FREE: begin
                        s_ff     <= f_off_c[31:0];
                        e_ff     <= f_end_c[31:0];
                        state_ff <= S_FR_WR;
                     end
                     OP_RESET: begin
                        span_count_ff <= '0;
                        cursor_ff     <= '0;
                        state_ff      <= S_RESP;
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            // first-fit scan
            S_AL_RD: begin
               dc_ff  <= '0;
               rem_ff <= '0;
               if (i_ff == span_count_ff) begin
                  dv_ff      <= cursor_ff;
                  div_cur_ff <= 1'b1;
                  state_ff   <= S_DIV;
               end else begin
                  state_ff <= S_AL_DATA;
               end
            end
            S_AL_DATA: begin
               s_ff       <= rd_data_ff.base;
               e_ff       <= rd_data_ff.limit;
               dv_ff      <= rd_data_ff.base;
               div_cur_ff <= 1'b0;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               dv_ff  <= dv_in;
               rem_ff <= rem_in;
               dc_ff  <= dc_ff + 1'b1;
               if (dc_ff == DIVC_W'(DIV_STEPS - 1)) begin
                  state_ff <= div_cur_ff ? S_CUR_CHK : S_AL_CHK;
               end
            end
            S_AL_CHK: begin
               if (!fit_c) begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_AL_RD;
               end else if (m_c > idx_type'(MAX_SPANS)) begin
                  res_status_ff <= ST_FULL;
                  state_ff      <= S_RESP;
               end else begin
                  o_ff         <= round_o[31:0];
                  e2_ff        <= slice_end[31:0];
                  gap_ff       <= gap_c;
                  rem_flag_ff  <= rem_c;
                  new_count_ff <= m_c;
                  j_ff         <= i_ff;
                  w_ff         <= span_count_ff - 1'b1;
                  state_ff     <= S_SH_RD;
               end
            end
            // close the hole left by the used span
            S_SH_RD: begin
               if ({1'b0, j_ff} + 1'b1 >= {1'b0, span_count_ff}) state_ff <= S_AP_GAP;
               else state_ff <= S_SH_WR;
            end
            S_SH_WR: begin
               j_ff     <= j_ff + 1'b1;
               state_ff <= S_SH_RD;
            end
            S_AP_GAP: begin
               if (gap_ff) w_ff <= w_ff + 1'b1;
               state_ff <= S_AP_REM;
            end
            S_AP_REM: begin
               span_count_ff <= new_count_ff;
               res_slice_ff  <= o_ff;
               res_from_ff   <= 1'b1;
               state_ff      <= S_RESP;
            end
            // bump cursor path
            S_CUR_CHK: begin
               if (slice_end > {2'b0, cap_ff}) begin
                  res_status_ff <= ST_CAP_EXC;
               end else begin
                  cursor_ff    <= slice_end[31:0];
                  res_slice_ff <= round_o[31:0];
               end
               state_ff <= S_RESP;
            end
            // free: place the new span after the list, rank all into scratch
            S_FR_WR:   state_ff <= S_RK_RDI;
            S_RK_RDI:  state_ff <= S_RK_GETI;
            S_RK_GETI: begin
               s_ff     <= rd_data_ff.base;
               e_ff     <= rd_data_ff.limit;
               rank_ff  <= '0;
               j_ff     <= idx_type'(1);
               state_ff <= S_RK_SCAN;
            end
            S_RK_SCAN: begin
               rank_ff <= rank_next;
               j_ff    <= j_ff + 1'b1;
               if (scan_last) begin
                  if (i_ff == span_count_ff) begin
                     kept_ff  <= '0;
                     have_ff  <= 1'b0;
                     state_ff <= S_MG_START;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_RK_RDI;
                  end
               end
            end
            // merge in place in scratch, then swap banks unless the list would overflow
            S_MG_START: begin
               j_ff     <= idx_type'(1);
               state_ff <= S_MG_RUN;
            end
            S_MG_RUN: begin
               j_ff <= j_ff + 1'b1;
               if (nz_c) begin
                  if (mrg_c) begin
                     if (rd_data_ff.limit > cur_ff.limit) cur_ff.limit <= rd_data_ff.limit;
                  end else begin
                     if (have_ff) kept_ff <= kept_ff + 1'b1;
                     cur_ff  <= rd_data_ff;
                     have_ff <= 1'b1;
                  end
               end
               if (scan_last) state_ff <= S_MG_FIN;
            end
            S_MG_FIN: begin
               if (total_c > idx_type'(MAX_SPANS)) begin
                  res_status_ff <= ST_FULL;
               end else begin
                  bank_ff       <= ~bank_ff;
                  span_count_ff <= total_c;
               end
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_slice_ff  <= res_slice_ff;
                  rsp_from_ff   <= res_from_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `AFFA_ASSERT(a_count_bound, clock, reset,
      span_count_ff <= idx_type'(MAX_SPANS), "span count over limit")
   `AFFA_ASSERT(a_req_leaves_idle, clock, reset,
      req_valid && req_ready |=> state_ff != S_IDLE, "request accepted without work")
   `AFFA_ASSERT(a_resp_loads, clock, reset,
      state_ff == S_RESP && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff && state_ff == S_IDLE,
      "result not delivered")
   `AFFA_ASSERT(a_fit_grant, clock, reset,
      state_ff == S_AP_REM |=> res_from_ff && res_status_ff == ST_OK, "fit without grant")
endmodule
